@@ rtl/pffl_pkg.sv @@
// Package for the page frame free list: sizes, request and status codes, register
// indexes and the packed types of a frame's attributes and of one result word.
// No dependencies.
package pffl_pkg;

	localparam int FRAME_COUNT = 1024;
	localparam int IDX_W       = $clog2(FRAME_COUNT);
	localparam int MAX_RUN     = 16;
	localparam int RUN_W       = 5;
	localparam int CNT_W       = 10;
	localparam int CFG_IDX_W   = 2;

	localparam logic [1:0] REQ_ALLOC     = 2'd0;
	localparam logic [1:0] REQ_FREE_HEAD = 2'd1;
	localparam logic [1:0] REQ_FREE_TAIL = 2'd2;
	localparam logic [1:0] REQ_UNLINK    = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_STATE  = 2'd2;

	localparam logic [1:0] OWN_SYSTEM = 2'd0;

	localparam logic [CFG_IDX_W-1:0] CFG_DESIRED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAITER  = 2'd2;

	localparam logic [CNT_W-1:0] DESIRED_RST = 10'd32;
	localparam logic [CNT_W-1:0] MINIMUM_RST = 10'd16;
	localparam logic [CNT_W-1:0] WAITER_RST  = 10'd4;

	localparam logic [IDX_W-1:0] HEADER = '0;

	typedef struct packed {
		logic       free;
		logic       gone;
		logic [1:0] ftype;
	} attr_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] frame_out;
		logic             clear_prev_owner;
		logic [1:0]       prev_type;
		logic [CNT_W-1:0] free_count;
		logic             below_desired;
		logic             wake_pager;
		logic             wake_waiters;
		logic             last;
	} res_t;

endpackage

@@ rtl/pffl_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module pffl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/page_frame_free_list.sv @@
// Page frame free list: a doubly linked list of free frames held in two link RAMs
// and an attribute RAM, with the header entry kept in registers. After reset the
// attribute RAM is cleared one entry a cycle, all 1024 entries, before the first word is
// accepted; configuration writes are taken at any time. Each memory has one read and
// one write port with a registered read, and a small sequencer walks every request
// through them: an unlink or a rejected request is answered from the check state, a free
// goes on through a link state, and an allocation takes its frames one at a time; a step
// that gives a result word waits while the previous word has not been taken.
// Depends on pffl_pkg and pffl_ram.
module page_frame_free_list
	import pffl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	input  logic [IDX_W-1:0]     frame_index,
	input  logic [RUN_W-1:0]     run_length,
	input  logic [1:0]           owner_type,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [IDX_W-1:0]     frame_out,
	output logic                 clear_prev_owner,
	output logic [1:0]           prev_type,
	output logic [CNT_W-1:0]     free_count,
	output logic                 below_desired,
	output logic                 wake_pager,
	output logic                 wake_waiters,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_AREAD,
		S_ASTEP,
		S_LINK
	} state_t;

	state_t           state_q, state_d;
	logic [1:0]       req_q;
	logic [IDX_W-1:0] frame_q;
	logic [RUN_W-1:0] left_q, left_d;
	logic [1:0]       owner_q;
	logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0] free_q, free_d;
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] desired_q, minimum_q, waiter_q;
	logic             out_valid_q;
	res_t             res_q, res_d;
	logic             emit;
	logic             slot_free;
	logic [RUN_W-1:0] run_sat;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] nxt_rd, prv_rd;
	attr_t            attr_rd;
	logic             nxt_we, prv_we, attr_we;
	logic [IDX_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, attr_wa;
	attr_t            attr_wd;
	logic [IDX_W-1:0] c_next;

	pffl_ram #(.WIDTH(IDX_W), .DEPTH(FRAME_COUNT)) u_next_ram (
		.clk  (clk),
		.we   (nxt_we),
		.waddr(nxt_wa),
		.wdata(nxt_wd),
		.raddr(rd_addr),
		.rdata(nxt_rd)
	);

	pffl_ram #(.WIDTH(IDX_W), .DEPTH(FRAME_COUNT)) u_prev_ram (
		.clk  (clk),
		.we   (prv_we),
		.waddr(prv_wa),
		.wdata(prv_wd),
		.raddr(rd_addr),
		.rdata(prv_rd)
	);

	pffl_ram #(.WIDTH($bits(attr_t)), .DEPTH(FRAME_COUNT)) u_attr_ram (
		.clk  (clk),
		.we   (attr_we),
		.waddr(attr_wa),
		.wdata(attr_wd),
		.raddr(rd_addr),
		.rdata(attr_rd)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign run_sat   = (run_length > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : run_length;
	assign c_next    = (head_q == HEADER) ? head_q : nxt_rd;

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = (req_type == REQ_ALLOC) ? head_q : frame_index;
		end else begin
			rd_addr = (req_q == REQ_ALLOC) ? head_q : frame_q;
		end
	end

	always_comb begin
		state_d = state_q;
		left_d  = left_q;
		head_d  = head_q;
		tail_d  = tail_q;
		free_d  = free_q;
		emit    = 1'b0;
		nxt_we  = 1'b0;
		nxt_wa  = frame_q;
		nxt_wd  = HEADER;
		prv_we  = 1'b0;
		prv_wa  = frame_q;
		prv_wd  = HEADER;
		attr_we = 1'b0;
		attr_wa = frame_q;
		attr_wd = attr_rd;
		res_d   = '0;
		res_d.status = ST_OK;
		res_d.last   = 1'b1;

		unique case (state_q)
			S_CLEAR: begin
				attr_we = 1'b1;
				attr_wa = clr_q;
				attr_wd = '0;
				if (clr_q == IDX_W'(FRAME_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
					left_d  = run_sat;
				end
			end
			S_CHECK: begin
				if (req_q == REQ_ALLOC) begin
					if (left_q == '0) begin
						emit = slot_free;
					end else if (CNT_W'(left_q) > free_q) begin
						emit         = slot_free;
						res_d.status = ST_NOFREE;
					end else begin
						state_d = S_ASTEP;
					end
				end else if (frame_q == HEADER) begin
					emit         = slot_free;
					res_d.status = ST_STATE;
				end else if (req_q == REQ_UNLINK) begin
					if (!attr_rd.free) begin
						emit         = slot_free;
						res_d.status = ST_STATE;
					end else if (slot_free) begin
						emit         = 1'b1;
						free_d       = free_q - CNT_W'(1);
						res_d.wake_pager = (free_d < minimum_q);
						attr_we      = 1'b1;
						attr_wd.free = 1'b0;
						if (prv_rd == HEADER) begin
							head_d = nxt_rd;
						end else begin
							nxt_we = 1'b1;
							nxt_wa = prv_rd;
							nxt_wd = nxt_rd;
						end
						if (nxt_rd == HEADER) begin
							tail_d = prv_rd;
						end else begin
							prv_we = 1'b1;
							prv_wa = nxt_rd;
							prv_wd = prv_rd;
						end
					end
				end else if (attr_rd.free) begin
					emit         = slot_free;
					res_d.status = ST_STATE;
				end else begin
					nxt_we       = 1'b1;
					prv_we       = 1'b1;
					attr_we      = 1'b1;
					attr_wd.free = 1'b1;
					if (req_q == REQ_FREE_HEAD) begin
						nxt_wd = head_q;
						prv_wd = HEADER;
						if (attr_rd.ftype != OWN_SYSTEM) begin
							attr_wd.gone = 1'b1;
						end
					end else begin
						nxt_wd = HEADER;
						prv_wd = tail_q;
					end
					state_d = S_LINK;
				end
				if (emit) begin
					state_d = S_IDLE;
				end
			end
			S_LINK: begin
				if (slot_free) begin
					emit   = 1'b1;
					free_d = free_q + CNT_W'(1);
					res_d.wake_waiters = (free_q < waiter_q);
					if (req_q == REQ_FREE_HEAD) begin
						if (head_q == HEADER) begin
							tail_d = frame_q;
						end else begin
							prv_we = 1'b1;
							prv_wa = head_q;
							prv_wd = frame_q;
						end
						head_d = frame_q;
					end else begin
						if (tail_q == HEADER) begin
							head_d = frame_q;
						end else begin
							nxt_we = 1'b1;
							nxt_wa = tail_q;
							nxt_wd = frame_q;
						end
						tail_d = frame_q;
					end
					state_d = S_IDLE;
				end
			end
			S_AREAD: begin
				state_d = S_ASTEP;
			end
			S_ASTEP: begin
				if (slot_free) begin
					emit    = 1'b1;
					free_d  = free_q - CNT_W'(1);
					left_d  = left_q - RUN_W'(1);
					head_d  = c_next;
					attr_we = 1'b1;
					attr_wa = head_q;
					attr_wd = '{free: 1'b0, gone: 1'b0, ftype: owner_q};
					if (c_next == HEADER) begin
						tail_d = HEADER;
					end else begin
						prv_we = 1'b1;
						prv_wa = c_next;
						prv_wd = HEADER;
					end
					res_d.frame_out        = head_q;
					res_d.prev_type        = attr_rd.ftype;
					res_d.clear_prev_owner = !attr_rd.gone && (attr_rd.ftype != OWN_SYSTEM);
					res_d.wake_pager       = (free_d < minimum_q);
					res_d.last             = (left_q == RUN_W'(1));
					state_d = res_d.last ? S_IDLE : S_AREAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.free_count    = free_d;
		res_d.below_desired = (free_d < desired_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			head_q      <= HEADER;
			tail_q      <= HEADER;
			free_q      <= '0;
			left_q      <= '0;
			req_q       <= REQ_ALLOC;
			frame_q     <= HEADER;
			owner_q     <= OWN_SYSTEM;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			desired_q   <= DESIRED_RST;
			minimum_q   <= MINIMUM_RST;
			waiter_q    <= WAITER_RST;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			free_q  <= free_d;
			left_q  <= left_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (in_valid && in_ready) begin
				req_q   <= req_type;
				frame_q <= frame_index;
				owner_q <= owner_type;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_DESIRED: desired_q <= cfg_data;
					CFG_MINIMUM: minimum_q <= cfg_data;
					CFG_WAITER:  waiter_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_q.status;
	assign frame_out        = res_q.frame_out;
	assign clear_prev_owner = res_q.clear_prev_owner;
	assign prev_type        = res_q.prev_type;
	assign free_count       = res_q.free_count;
	assign below_desired    = res_q.below_desired;
	assign wake_pager       = res_q.wake_pager;
	assign wake_waiters     = res_q.wake_waiters;
	assign last             = res_q.last;

	// A new result word is only loaded when the previous one has gone.
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result word overwritten");

	// The final word of a request returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_d.last) |=> (state_q == S_IDLE))
		else $error("sequencer busy after final word");

	// An empty list has both header links pointing at the header.
	a_empty_header: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && free_q == '0) |-> (head_q == HEADER && tail_q == HEADER))
		else $error("header links inconsistent with empty list");

	// The link memories are left alone during the clearing pass.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> (!nxt_we && !prv_we && !emit))
		else $error("link write during clearing pass");

endmodule
